[src/hra_pkg.sv]
// Shared types and constants of the HID report message assembler.
package hra_pkg;

	// Report layout.
	localparam int REPORT_BYTES = 64;
	localparam int INIT_FLAG_BIT = 7;
	localparam logic [7:0] CMD_MASK = 8'h7f;
	localparam int INIT_CHUNK = 57;
	localparam int CONT_CHUNK = 59;
	localparam int INIT_HDR_BYTES = 7;
	localparam int CONT_HDR_BYTES = 5;
	localparam int CHAN_BYTES = 4;
	localparam int MARKER_POS = 4;
	localparam logic [6:0] POS_MAX = 7'd127;

	// Action and result kind codes.
	localparam logic ACT_REPORT = 1'b0;
	localparam logic ACT_READ = 1'b1;
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// Report status codes.
	typedef enum logic [2:0] {
		ST_PROGRESS = 3'd0,
		ST_COMPLETE = 3'd1,
		ST_BADLEN   = 3'd2,
		ST_BADSEQ   = 3'd3,
		ST_BUSY     = 3'd4
	} status_t;

	// Result that a queued operation produces in the back end.
	typedef enum logic [1:0] {
		RES_NONE,
		RES_STATUS,
		RES_READ,
		RES_READ_ZERO
	} res_t;

	// Input word.
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       report_end;
		logic [9:0] read_index;
	} req_t;

	// Output word.
	typedef struct packed {
		logic        kind;
		logic [2:0]  status;
		logic [31:0] channel_id;
		logic [6:0]  command;
		logic [10:0] message_length;
		logic [7:0]  read_byte;
	} rsp_t;

	// Operation handed from the front end to the back end (address travels beside it).
	typedef struct packed {
		logic        wr_en;
		res_t        res;
		logic [7:0]  data;
		status_t     status;
		logic [31:0] channel;
		logic [6:0]  command;
		logic [10:0] length;
	} op_t;

endpackage

[src/hra_front.sv]
// Front end: parses report bytes, tracks the assembly and issues store and result operations.
module hra_front import hra_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 1024,
	localparam int AW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1,
	localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  req_t          req,
	input  logic          op_full,
	output logic          op_valid,
	output op_t           op,
	output logic [AW-1:0] op_addr
);

	// Assembly and frame state.
	logic          assembling_q;
	logic [31:0]   held_channel_q;
	logic [6:0]    held_command_q;
	logic [CW-1:0] expected_q;
	logic [CW-1:0] received_q;
	logic [7:0]    next_seq_q;
	logic [6:0]    pos_q;
	logic [31:0]   frame_channel_q;
	logic [7:0]    frame_marker_q;
	logic [15:0]   frame_declared_q;

	logic          accept;
	logic          is_byte;
	logic          is_init;
	logic          decl_ok;
	logic          cont_ok;
	logic [6:0]    init_off;
	logic [6:0]    cont_off;
	logic [CW-1:0] rem;
	logic [CW:0]   cont_sum;
	logic          in_body;
	logic          wr_init;
	logic          wr_cont;
	logic          len_ok;
	logic [7:0]    count;

	logic          nx_assembling;
	logic [31:0]   nx_held_channel;
	logic [6:0]    nx_held_command;
	logic [CW-1:0] nx_expected;
	logic [CW-1:0] nx_received;
	logic [7:0]    nx_next_seq;
	logic [CW-1:0] cont_add;
	logic [CW-1:0] init_rec;
	logic          done;
	status_t       fin_status;
	logic [31:0]   cpl_channel;
	logic [6:0]    cpl_command;
	logic [10:0]   cpl_length;

	// A word is taken whenever the queue has room.
	assign req_stall = op_full;
	assign accept = req_valid && !op_full;
	assign is_byte = accept && (req.action == ACT_REPORT);

	// Header checks against the bytes seen so far.
	assign is_init = frame_marker_q[INIT_FLAG_BIT];
	assign decl_ok = 32'(frame_declared_q) <= MAX_MESSAGE_BYTES;
	assign cont_ok = assembling_q && (frame_channel_q == held_channel_q)
		&& (frame_marker_q == next_seq_q);
	assign rem = (expected_q > received_q) ? (expected_q - received_q) : '0;
	assign init_off = pos_q - 7'(INIT_HDR_BYTES);
	assign cont_off = pos_q - 7'(CONT_HDR_BYTES);
	assign cont_sum = (CW + 1)'(received_q) + (CW + 1)'(cont_off);
	assign in_body = 32'(pos_q) < REPORT_BYTES;

	// Payload bytes are written as they arrive when the header would accept the report.
	assign wr_init = in_body && is_init && (32'(pos_q) >= INIT_HDR_BYTES) && !assembling_q
		&& decl_ok && (16'(init_off) < frame_declared_q);
	assign wr_cont = in_body && !is_init && (32'(pos_q) >= CONT_HDR_BYTES) && cont_ok
		&& (32'(cont_off) < 32'(rem)) && (32'(cont_sum) < MAX_MESSAGE_BYTES);

	// Report end: length check, then init or continuation handling.
	assign count = 8'(pos_q) + 8'd1;
	assign len_ok = 32'(count) == REPORT_BYTES;
	assign cont_add = (32'(rem) < CONT_CHUNK) ? rem : CW'(CONT_CHUNK);
	assign init_rec = (32'(frame_declared_q) < INIT_CHUNK) ? CW'(frame_declared_q)
		: CW'(INIT_CHUNK);

	always_comb begin
		nx_assembling = assembling_q;
		nx_held_channel = held_channel_q;
		nx_held_command = held_command_q;
		nx_expected = expected_q;
		nx_received = received_q;
		nx_next_seq = next_seq_q;
		done = 1'b0;
		fin_status = ST_PROGRESS;
		cpl_channel = '0;
		cpl_command = '0;
		cpl_length = '0;
		if (!len_ok) begin
			fin_status = ST_BADLEN;
		end else if (is_init) begin
			if (assembling_q) begin
				fin_status = ST_BUSY;
			end else if (!decl_ok) begin
				fin_status = ST_BADLEN;
			end else begin
				nx_assembling = 1'b1;
				nx_held_channel = frame_channel_q;
				nx_held_command = 7'(frame_marker_q & CMD_MASK);
				nx_expected = CW'(frame_declared_q);
				nx_received = init_rec;
				nx_next_seq = '0;
				done = 1'b1;
			end
		end else if (!cont_ok) begin
			nx_assembling = 1'b0;
			nx_held_channel = '0;
			nx_held_command = '0;
			nx_expected = '0;
			nx_received = '0;
			nx_next_seq = '0;
			fin_status = ST_BADSEQ;
		end else begin
			nx_next_seq = next_seq_q + 8'd1;
			nx_received = received_q + cont_add;
			done = 1'b1;
		end
		// Completion hands out the message and drops the assembly.
		if (done && (nx_received >= nx_expected)) begin
			fin_status = ST_COMPLETE;
			cpl_channel = nx_held_channel;
			cpl_command = nx_held_command;
			cpl_length = 11'(nx_expected);
			nx_assembling = 1'b0;
			nx_held_channel = '0;
			nx_held_command = '0;
			nx_expected = '0;
			nx_received = '0;
			nx_next_seq = '0;
		end
	end

	// Operation for the back end.
	always_comb begin
		op = '0;
		op.data = req.data_byte;
		op.res = RES_NONE;
		op.status = ST_PROGRESS;
		op_addr = '0;
		if (req.action == ACT_READ) begin
			op.res = (32'(req.read_index) < MAX_MESSAGE_BYTES) ? RES_READ : RES_READ_ZERO;
			op_addr = AW'(req.read_index);
		end else begin
			op.wr_en = wr_init || wr_cont;
			if (wr_init) begin
				op_addr = AW'(init_off);
			end else begin
				op_addr = AW'(cont_sum);
			end
			if (req.report_end) begin
				op.res = RES_STATUS;
				op.status = fin_status;
				op.channel = cpl_channel;
				op.command = cpl_command;
				op.length = cpl_length;
			end
		end
	end

	assign op_valid = accept && (op.wr_en || (op.res != RES_NONE));

	// State update on each report byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assembling_q <= 1'b0;
			held_channel_q <= '0;
			held_command_q <= '0;
			expected_q <= '0;
			received_q <= '0;
			next_seq_q <= '0;
			pos_q <= '0;
			frame_channel_q <= '0;
			frame_marker_q <= '0;
			frame_declared_q <= '0;
		end else if (is_byte) begin
			if (req.report_end) begin
				assembling_q <= nx_assembling;
				held_channel_q <= nx_held_channel;
				held_command_q <= nx_held_command;
				expected_q <= nx_expected;
				received_q <= nx_received;
				next_seq_q <= nx_next_seq;
				pos_q <= '0;
				frame_channel_q <= '0;
				frame_marker_q <= '0;
				frame_declared_q <= '0;
			end else begin
				if (32'(pos_q) < CHAN_BYTES) begin
					frame_channel_q <= {frame_channel_q[23:0], req.data_byte};
				end else if (32'(pos_q) == MARKER_POS) begin
					frame_marker_q <= req.data_byte;
				end else if (is_init && (32'(pos_q) < INIT_HDR_BYTES)) begin
					frame_declared_q <= {frame_declared_q[7:0], req.data_byte};
				end
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
			end
		end
	end

endmodule

[src/hra_queue.sv]
// Small first-in first-out queue between the front and back ends.
module hra_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [NW-1:0]    count_q;

	assign full = count_q == NW'(DEPTH);
	assign empty = count_q == '0;
	assign dout = slot_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

[src/hra_back.sv]
// Back end: payload store, store reads and the registered output word.
module hra_back import hra_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 1024,
	localparam int AW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  op_t           head,
	input  logic [AW-1:0] head_addr,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rsp_t          rsp
);

	logic [7:0]  store_q [MAX_MESSAGE_BYTES];
	logic [7:0]  rd_byte_q;
	logic        rsp_valid_s1;
	res_t        res_s1;
	status_t     status_s1;
	logic [31:0] channel_s1;
	logic [6:0]  command_s1;
	logic [10:0] length_s1;
	logic        s1_free;
	logic        has_res;
	logic        load_s1;

	// An operation without a result never waits; one with a result waits for the output register.
	assign s1_free = !rsp_valid_s1 || !rsp_stall;
	assign has_res = head.res != RES_NONE;
	assign pop = head_valid && (!has_res || s1_free);
	assign load_s1 = pop && has_res;

	// Payload store with registered read data.
	always_ff @(posedge clk) begin
		if (pop && head.wr_en) begin
			store_q[head_addr] <= head.data;
		end
		if (pop && (head.res == RES_READ)) begin
			rd_byte_q <= store_q[head_addr];
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else if (s1_free) begin
			rsp_valid_s1 <= load_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			res_s1 <= head.res;
			status_s1 <= head.status;
			channel_s1 <= head.channel;
			command_s1 <= head.command;
			length_s1 <= head.length;
		end
	end

	assign rsp_valid = rsp_valid_s1;
	assign rsp.kind = (res_s1 == RES_STATUS) ? KIND_STATUS : KIND_READ;
	assign rsp.status = (res_s1 == RES_STATUS) ? status_s1 : ST_PROGRESS;
	assign rsp.channel_id = channel_s1;
	assign rsp.command = command_s1;
	assign rsp.message_length = length_s1;
	assign rsp.read_byte = (res_s1 == RES_READ) ? rd_byte_q : 8'h00;

endmodule

[src/hid_report_message_assembler.sv]
// Top level of the HID report message assembler: front end, queue and back end.
//
// The block takes one word per clock cycle, report bytes and store reads alike, and gives
// at most one result word per input word. A report byte is parsed and checked by the front
// end in the cycle it is accepted; its store write and any status go through a queue of
// QUEUE_DEPTH entries to the back end, which writes or reads the payload store (one port,
// one access per cycle) and holds the result in an output register. With an empty queue
// and an output that is not stalled, an accepted word passes its queue entry and then
// the output register before its result is valid. While the output stalls, words are still
// taken until QUEUE_DEPTH operations wait in the queue behind the held result, then req_stall
// rises; report bytes that neither write the store nor end a report take no queue entry.
// Reads and writes reach the store in arrival order, so a read sees every payload byte
// written by earlier words. The store has no reset; an unwritten entry reads as an arbitrary byte.
module hid_report_message_assembler import hra_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 1024,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
	localparam int QW = $bits(op_t) + AW;

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	op_t           f_op;
	logic [AW-1:0] f_addr;
	op_t           head;
	logic [AW-1:0] head_addr;
	logic [QW-1:0] q_din;
	logic [QW-1:0] q_dout;

	// Parse and classify incoming words.
	hra_front #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.op_full  (q_full),
		.op_valid (q_push),
		.op       (f_op),
		.op_addr  (f_addr)
	);

	assign q_din = {f_op, f_addr};

	// Operation queue.
	hra_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign head = q_dout[QW-1:AW];
	assign head_addr = q_dout[AW-1:0];

	// Store access and result output.
	hra_back #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(!q_empty),
		.head      (head),
		.head_addr (head_addr),
		.pop       (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// The front end never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	// The back end never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");

	// Every queued entry either writes the store or produces a result.
	a_no_idle_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && (head.res == RES_NONE)) |-> head.wr_en)
		else $error("queued entry does nothing");

	// A store read never writes the store.
	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && (head.res == RES_READ)) |-> !head.wr_en)
		else $error("read entry also writes");

endmodule

[tb/sv/tb_hid_report_message_assembler.sv]
// Self-checking testbench of the HID report message assembler, with a reassembly predictor.
`timescale 1ns / 100ps

module tb_hid_report_message_assembler import hra_pkg::*; ();

	localparam int MAX_MSG = 1024;
	localparam int RANDOM_WORDS = 1000;
	localparam int LONG_HOLD = 200;
	localparam int HOLD_READS = 40;
	localparam int TAIL_CYCLES = 20;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP = 50;

	// Kinds of rows in the directed table.
	typedef enum logic [1:0] {
		ROW_INIT,
		ROW_CONT,
		ROW_READ,
		ROW_MSG
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] chan;
		logic [7:0]  marker;    // command for an init, sequence for a continuation
		logic [15:0] declared;
		int          nbytes;
		logic [7:0]  fill;
		logic [9:0]  index;
		bit          typed;
		status_t     status;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Assembly and report state of the predictor.
	logic        busy_asm = 1'b0;
	logic [31:0] asm_channel = '0;
	logic [6:0]  asm_command = '0;
	logic [10:0] asm_expected = '0;
	logic [10:0] asm_received = '0;
	logic [7:0]  asm_seq = '0;
	logic [6:0]  rpt_pos = '0;
	logic [31:0] rpt_channel = '0;
	logic [7:0]  rpt_marker = '0;
	logic [15:0] rpt_declared = '0;
	logic [7:0]  store_mirror [MAX_MSG];
	bit          store_known [MAX_MSG];
	int          written_list [$];

	rsp_t     awaited_words [$];
	dir_row_t dir_rows [$];
	rsp_t     typed_word;
	bit       typed_pending = 1'b0;
	bit       hold_go = 1'b0;
	int       send_idle_pct = 0;
	int       stall_pct = 0;
	int       read_mix_pct = 0;
	int       words_sent = 0;
	int       results_checked = 0;
	int       mismatch_count = 0;
	int       cycle_count = 0;

	hid_report_message_assembler #(.MAX_MESSAGE_BYTES(MAX_MSG)) DUT (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	function automatic bit cont_matches();
		return busy_asm && rpt_channel == asm_channel && rpt_marker == asm_seq;
	endfunction

	task automatic drop_assembly();
		busy_asm = 1'b0;
		asm_channel = '0;
		asm_command = '0;
		asm_expected = '0;
		asm_received = '0;
		asm_seq = '0;
	endtask

	task automatic note_store(input int idx, input logic [7:0] v);
		store_mirror[idx] = v;
		if (!store_known[idx]) begin
			store_known[idx] = 1'b1;
			written_list.push_back(idx);
		end
	endtask

	// Predicts the result of one accepted word and advances the predictor state.
	task automatic reassemble_word(input req_t w, output bit has_rsp, output rsp_t r);
		int pos;
		int off;
		int remain;
		logic [7:0] d;
		r = '0;
		has_rsp = 1'b0;
		d = w.data_byte;
		if (w.action == ACT_READ) begin
			r.kind = KIND_READ;
			if (int'(w.read_index) < MAX_MSG)
				r.read_byte = store_mirror[w.read_index];
			has_rsp = 1'b1;
			return;
		end
		pos = int'(rpt_pos);
		// Header capture and speculative payload writes.
		if (pos < CHAN_BYTES) begin
			rpt_channel = {rpt_channel[23:0], d};
		end else if (pos == MARKER_POS) begin
			rpt_marker = d;
		end else if (pos < REPORT_BYTES) begin
			if (rpt_marker[INIT_FLAG_BIT]) begin
				if (pos < INIT_HDR_BYTES) begin
					rpt_declared = {rpt_declared[7:0], d};
				end else if (!busy_asm && int'(rpt_declared) <= MAX_MSG) begin
					off = pos - INIT_HDR_BYTES;
					if (off < min_int(int'(rpt_declared), INIT_CHUNK))
						note_store(off, d);
				end
			end else if (cont_matches()) begin
				off = pos - CONT_HDR_BYTES;
				remain = (asm_expected > asm_received) ? int'(asm_expected - asm_received) : 0;
				if (off < min_int(remain, CONT_CHUNK))
					note_store(int'(asm_received) + off, d);
			end
		end
		if (!w.report_end) begin
			if (rpt_pos < POS_MAX)
				rpt_pos++;
			return;
		end
		// Report end: length, busy and sequence checks, then the status.
		r.kind = KIND_STATUS;
		if (pos + 1 != REPORT_BYTES) begin
			r.status = ST_BADLEN;
		end else if (rpt_marker[INIT_FLAG_BIT] && busy_asm) begin
			r.status = ST_BUSY;
		end else if (rpt_marker[INIT_FLAG_BIT] && int'(rpt_declared) > MAX_MSG) begin
			r.status = ST_BADLEN;
		end else if (!rpt_marker[INIT_FLAG_BIT] && !cont_matches()) begin
			drop_assembly();
			r.status = ST_BADSEQ;
		end else begin
			if (rpt_marker[INIT_FLAG_BIT]) begin
				busy_asm = 1'b1;
				asm_channel = rpt_channel;
				asm_command = rpt_marker[6:0];
				asm_expected = rpt_declared[10:0];
				asm_received = 11'(min_int(int'(rpt_declared), INIT_CHUNK));
				asm_seq = '0;
			end else begin
				asm_seq++;
				remain = (asm_expected > asm_received) ? int'(asm_expected - asm_received) : 0;
				asm_received = 11'(int'(asm_received) + min_int(remain, CONT_CHUNK));
			end
			if (asm_received < asm_expected) begin
				r.status = ST_PROGRESS;
			end else begin
				r.status = ST_COMPLETE;
				r.channel_id = asm_channel;
				r.command = asm_command;
				r.message_length = asm_expected;
				drop_assembly();
			end
		end
		rpt_pos = '0;
		rpt_channel = '0;
		rpt_marker = '0;
		rpt_declared = '0;
		has_rsp = 1'b1;
	endtask

	// Offers one word, waits for it to be taken and records what it should produce.
	task automatic send_word(input req_t w);
		bit has_rsp;
		rsp_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		words_sent++;
		reassemble_word(w, has_rsp, want);
		if (has_rsp) begin
			if (typed_pending && want.kind == KIND_STATUS) begin
				want = typed_word;
				typed_pending = 1'b0;
			end
			awaited_words.push_back(want);
		end
	endtask

	task automatic send_read(input int idx);
		req_t w;
		w.action = ACT_READ;
		w.data_byte = 8'($urandom);
		w.report_end = 1'($urandom);
		w.read_index = 10'(idx);
		send_word(w);
	endtask

	// Reads an entry that some earlier word has written.
	task automatic send_known_read();
		if (written_list.size() == 0)
			return;
		send_read(written_list[$urandom_range(written_list.size() - 1)]);
	endtask

	// Sends one report of nbytes bytes; reads may be mixed in between its bytes.
	task automatic send_report(input logic [31:0] chan, input logic [7:0] marker,
			input logic [15:0] declared, input int nbytes, input bit rnd_fill,
			input logic [7:0] fill);
		req_t w;
		logic [7:0] b;
		for (int i = 0; i < nbytes; i++) begin
			if (read_mix_pct > 0 && $urandom_range(99) < read_mix_pct)
				send_known_read();
			if (i < CHAN_BYTES)
				b = chan[31 - 8 * i -: 8];
			else if (i == MARKER_POS)
				b = marker;
			else if (marker[INIT_FLAG_BIT] && i == MARKER_POS + 1)
				b = declared[15:8];
			else if (marker[INIT_FLAG_BIT] && i == MARKER_POS + 2)
				b = declared[7:0];
			else
				b = rnd_fill ? 8'($urandom) : fill;
			w.action = ACT_REPORT;
			w.data_byte = b;
			w.report_end = (i == nbytes - 1);
			w.read_index = 10'($urandom);
			send_word(w);
		end
	endtask

	// Sends a whole message: an init and as many continuations as its length needs.
	// With interject set, a second init and a short report land inside the message.
	task automatic send_message(input logic [31:0] chan, input logic [6:0] cmd,
			input logic [15:0] declared, input bit interject, input int between_pct);
		int got;
		logic [7:0] seq;
		got = min_int(int'(declared), INIT_CHUNK);
		seq = '0;
		send_report(chan, {1'b1, cmd}, declared, REPORT_BYTES, 1'b1, 8'h00);
		if (interject) begin
			send_report(32'($urandom), {1'b1, 7'($urandom)}, 16'($urandom_range(0, 100)),
				REPORT_BYTES, 1'b1, 8'h00);
			send_report(chan, seq, 16'h0000, $urandom_range(1, REPORT_BYTES - 1), 1'b1, 8'h00);
		end
		while (got < int'(declared)) begin
			if ($urandom_range(99) < between_pct)
				send_known_read();
			send_report(chan, seq, 16'h0000, REPORT_BYTES, 1'b1, 8'h00);
			got += CONT_CHUNK;
			seq++;
		end
	endtask

	// Stops offering words until every awaited result has come.
	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_words.size() != 0);
	endtask

	task automatic add_row(input row_kind_t k, input logic [31:0] ch, input logic [7:0] mk,
			input logic [15:0] dl, input int nb, input logic [7:0] fl, input logic [9:0] ix,
			input bit ty, input status_t st);
		dir_row_t row;
		row.kind = k;
		row.chan = ch;
		row.marker = mk;
		row.declared = dl;
		row.nbytes = nb;
		row.fill = fl;
		row.index = ix;
		row.typed = ty;
		row.status = st;
		dir_rows.push_back(row);
	endtask

	function automatic logic [31:0] rand_channel();
		case ($urandom_range(3))
			0: return 32'hffff_ffff;
			1: return 32'h0000_0000;
			2: return 32'h1000_0001;
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_length();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return 16'($urandom_range(0, 180));
		else if (r < 95)
			return 16'($urandom_range(181, 600));
		else if (r < 99)
			return 16'($urandom_range(900, MAX_MSG));
		return 16'(MAX_MSG);
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch in %s at result %0d: got %0h, wanted %0h",
				field, results_checked, got, want);
		mismatch_count++;
	endtask

	// Receiver: random stall, or a long hold-off counted here when asked for.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Result checker: each accepted word against the oldest awaited one.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_words.size() == 0) begin
				report_mismatch("word with nothing awaited", 64'(rsp), 64'h0);
			end else begin
				want = awaited_words.pop_front();
				if (rsp.kind !== want.kind)
					report_mismatch("kind", 64'(rsp.kind), 64'(want.kind));
				if (rsp.status !== want.status)
					report_mismatch("status", 64'(rsp.status), 64'(want.status));
				if (rsp.channel_id !== want.channel_id)
					report_mismatch("channel_id", 64'(rsp.channel_id), 64'(want.channel_id));
				if (rsp.command !== want.command)
					report_mismatch("command", 64'(rsp.command), 64'(want.command));
				if (rsp.message_length !== want.message_length)
					report_mismatch("message_length", 64'(rsp.message_length),
						64'(want.message_length));
				if (rsp.read_byte !== want.read_byte)
					report_mismatch("read_byte", 64'(rsp.read_byte), 64'(want.read_byte));
			end
			results_checked++;
		end
	end

	// Stimulus.
	initial begin
		int random_start;
		int phase;
		int mode;
		int new_phase;
		logic [31:0] ch;

		// Directed table: extremes, every status and the report corner cases.
		add_row(ROW_INIT, 32'hffff_ffff, 8'h7f, 16'd0, 64, 8'h00, 10'd0, 1'b1, ST_COMPLETE);
		add_row(ROW_INIT, 32'h0000_0000, 8'h00, 16'd1025, 64, 8'h00, 10'd0, 1'b1, ST_BADLEN);
		add_row(ROW_INIT, 32'h0000_0001, 8'h05, 16'hffff, 64, 8'h00, 10'd0, 1'b1, ST_BADLEN);
		add_row(ROW_CONT, 32'h0000_0001, 8'h00, 16'd0, 64, 8'h00, 10'd0, 1'b1, ST_BADSEQ);
		add_row(ROW_INIT, 32'h1234_5678, 8'h01, 16'd1024, 64, 8'hff, 10'd0, 1'b1, ST_PROGRESS);
		add_row(ROW_READ, 32'h0, 8'h00, 16'd0, 0, 8'h00, 10'd0, 1'b0, ST_PROGRESS);
		add_row(ROW_READ, 32'h0, 8'h00, 16'd0, 0, 8'h00, 10'd56, 1'b0, ST_PROGRESS);
		add_row(ROW_INIT, 32'h1234_5678, 8'h02, 16'd10, 64, 8'h00, 10'd0, 1'b1, ST_BUSY);
		add_row(ROW_CONT, 32'h8765_4321, 8'h00, 16'd0, 64, 8'h00, 10'd0, 1'b1, ST_BADSEQ);
		add_row(ROW_INIT, 32'ha5a5_a5a5, 8'h40, 16'd200, 64, 8'h00, 10'd0, 1'b1, ST_PROGRESS);
		add_row(ROW_CONT, 32'ha5a5_a5a5, 8'h00, 16'd0, 64, 8'h55, 10'd0, 1'b1, ST_PROGRESS);
		add_row(ROW_CONT, 32'ha5a5_a5a5, 8'h02, 16'd0, 64, 8'h00, 10'd0, 1'b1, ST_BADSEQ);
		add_row(ROW_INIT, 32'h0000_beef, 8'h3f, 16'd58, 64, 8'h0f, 10'd0, 1'b1, ST_PROGRESS);
		add_row(ROW_CONT, 32'h0000_beef, 8'h00, 16'd0, 10, 8'h33, 10'd0, 1'b1, ST_BADLEN);
		add_row(ROW_CONT, 32'h0000_beef, 8'h00, 16'd0, 70, 8'h44, 10'd0, 1'b1, ST_BADLEN);
		add_row(ROW_CONT, 32'h0000_beef, 8'h00, 16'd0, 130, 8'h66, 10'd0, 1'b1, ST_BADLEN);
		add_row(ROW_CONT, 32'h0000_beef, 8'h00, 16'd0, 1, 8'h00, 10'd0, 1'b1, ST_BADLEN);
		add_row(ROW_CONT, 32'h0000_beef, 8'h00, 16'd0, 64, 8'hf0, 10'd0, 1'b0, ST_PROGRESS);
		add_row(ROW_READ, 32'h0, 8'h00, 16'd0, 0, 8'h00, 10'd57, 1'b0, ST_PROGRESS);
		add_row(ROW_INIT, 32'h0000_0000, 8'h00, 16'd57, 64, 8'haa, 10'd0, 1'b1, ST_COMPLETE);
		add_row(ROW_MSG, 32'h8000_0001, 8'h7f, 16'd1024, 64, 8'h00, 10'd0, 1'b0, ST_PROGRESS);
		add_row(ROW_READ, 32'h0, 8'h00, 16'd0, 0, 8'h00, 10'd1023, 1'b0, ST_PROGRESS);
		add_row(ROW_READ, 32'h0, 8'h00, 16'd0, 0, 8'h00, 10'd512, 1'b0, ST_PROGRESS);

		// Single reset at the start.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, one row at a time.
		foreach (dir_rows[i]) begin
			typed_word = '0;
			typed_word.kind = KIND_STATUS;
			typed_word.status = dir_rows[i].status;
			if (dir_rows[i].status == ST_COMPLETE) begin
				typed_word.channel_id = dir_rows[i].chan;
				typed_word.command = dir_rows[i].marker[6:0];
				typed_word.message_length = dir_rows[i].declared[10:0];
			end
			typed_pending = dir_rows[i].typed;
			case (dir_rows[i].kind)
				ROW_INIT: begin
					send_report(dir_rows[i].chan, {1'b1, dir_rows[i].marker[6:0]},
						dir_rows[i].declared, dir_rows[i].nbytes, 1'b0, dir_rows[i].fill);
				end
				ROW_CONT: begin
					send_report(dir_rows[i].chan, dir_rows[i].marker, 16'h0000,
						dir_rows[i].nbytes, 1'b0, dir_rows[i].fill);
				end
				ROW_MSG: begin
					send_message(dir_rows[i].chan, dir_rows[i].marker[6:0],
						dir_rows[i].declared, 1'b0, 0);
				end
				default: begin
					send_read(int'(dir_rows[i].index));
				end
			endcase
		end
		drain_results();

		// Long receiver hold-off while reads keep coming, so the input stalls.
		hold_go = 1'b1;
		for (int i = 0; i < HOLD_READS; i++)
			send_known_read();
		drain_results();

		// Random part, rotating through the idling phases.
		read_mix_pct = 2;
		random_start = words_sent;
		phase = -1;
		while (words_sent - random_start < RANDOM_WORDS) begin
			new_phase = ((words_sent - random_start) / 250) % 4;
			if (new_phase != phase) begin
				phase = new_phase;
				drain_results();
				case (phase)
					0: begin send_idle_pct = 0; stall_pct = 0; end
					1: begin send_idle_pct = 69; stall_pct = 0; end
					2: begin send_idle_pct = 0; stall_pct = 69; end
					default: begin send_idle_pct = 7; stall_pct = 7; end
				endcase
			end
			mode = $urandom_range(99);
			if (mode < 60) begin
				// Well-formed message with random content.
				send_message(rand_channel(), 7'($urandom), rand_length(), 1'b0, 10);
			end else if (mode < 70) begin
				repeat ($urandom_range(1, 4))
					send_known_read();
			end else if (mode < 78) begin
				// Lone continuation, matching a live assembly only now and then.
				ch = (busy_asm && $urandom_range(1)) ? asm_channel : rand_channel();
				send_report(ch, $urandom_range(1) ? asm_seq : 8'($urandom_range(0, 2)),
					16'h0000, REPORT_BYTES, 1'b1, 8'h00);
			end else if (mode < 85) begin
				send_report(rand_channel(), {1'b1, 7'($urandom)}, 16'($urandom),
					REPORT_BYTES, 1'b1, 8'h00);
			end else if (mode < 93) begin
				// Report of the wrong length with an arbitrary marker.
				send_report(rand_channel(), 8'($urandom), 16'($urandom),
					$urandom_range(1) ? $urandom_range(1, REPORT_BYTES - 1)
						: $urandom_range(REPORT_BYTES + 1, 140),
					1'b1, 8'h00);
			end else begin
				send_message(rand_channel(), 7'($urandom), 16'($urandom_range(58, 300)),
					1'b1, 10);
			end
		end

		// Let everything out, then wait out the pipeline.
		send_idle_pct = 0;
		stall_pct = 0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_words.size() != 0)
			report_mismatch("results never delivered", 64'(awaited_words.size()), 64'h0);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
